// ===== rtl/gmt_pkg.sv =====
// Shared types and constants for the gossip membership table.
package gmt_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_JOIN  = 2'd0,
    OP_MERGE = 2'd1,
    OP_TICK  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_KEPT    = 3'd2,
    ST_DROPPED = 3'd3,
    ST_FULL    = 3'd4,
    ST_TICKED  = 3'd5,
    ST_READ_OK = 3'd6,
    ST_EMPTY   = 3'd7
  } status_t;

  localparam logic [1:0] CFG_FAIL_TO   = 2'd0;
  localparam logic [1:0] CFG_REMOVE_TO = 2'd1;
  localparam logic [1:0] CFG_SELF_ID   = 2'd2;
  localparam logic [1:0] CFG_SELF_PORT = 2'd3;

  // One member record.
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [30:0] tm;
  } entry_t;

  // Command handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic        dropped;
    entry_t      ent;
    logic [30:0] now;
    logic [5:0]  ridx;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    entry_t      ent;
    logic [6:0]  count;
    logic [6:0]  removed;
  } res_t;
endpackage

// ===== rtl/gmt_front.sv =====
// Front: accepts input beats, does the fail-age check, queues commands.
module gmt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gmt_pkg::cmd_t   in_cmd,
  input  logic [15:0]     fail_timeout,
  output logic            q_valid,
  input  logic            q_ready,
  output gmt_pkg::cmd_t   q_cmd
);
  import gmt_pkg::*;

  cmd_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [31:0] age;
  cmd_t       c;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = fifo_r[rp_r];

  always_comb begin
    c = in_cmd;
    age = {1'b0, in_cmd.now} - {1'b0, in_cmd.ent.tm};
    c.dropped = (in_cmd.op == OP_MERGE) && !age[31] && (age[30:0] >= {15'd0, fail_timeout});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        fifo_r[wp_r] <= c;
        wp_r <= ~wp_r;
      end
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> !q_valid)
    else $error("empty queue valid");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(q_valid && q_ready)) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("count slip");
endmodule

// ===== rtl/gmt_back.sv =====
// Back: sequencer over the member table memory.
module gmt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  gmt_pkg::cmd_t   q_cmd,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [31:0]     cfg_data,
  input  logic [15:0]     remove_timeout,
  output logic            res_valid,
  input  logic            res_ready,
  output gmt_pkg::res_t   res
);
  import gmt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CHK   = 6'b000100,
    S_FIN   = 6'b001000,
    S_OUT   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  entry_t      mem [TABLE_DEPTH];
  entry_t      e0_r;      // entry zero held in registers
  entry_t      rd_r;
  state_t      st_r, st_nxt;
  cmd_t        cmd_r;
  cmd_t        acc_cmd;
  logic [CNT_W-1:0] count_r, k_r, kept_r, rem_r;
  logic [31:0] own_hb_r;
  res_t        res_r;
  logic        rv_r;
  entry_t      cur;
  entry_t      upd;
  logic [31:0] age;
  logic        stale, match, newer;
  logic        mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t      mem_wd;

  assign q_ready   = (st_r == S_IDLE) && !rv_r;
  assign res_valid = rv_r;
  assign res       = res_r;

  // current entry: index 0 from registers, others from memory
  assign cur   = (k_r == '0) ? e0_r : rd_r;
  assign age   = {1'b0, cmd_r.now} - {1'b0, cur.tm};
  assign stale = !age[31] && (age[30:0] > {15'd0, remove_timeout});
  assign match = (cur.id == cmd_r.ent.id) && (cur.port == cmd_r.ent.port);
  assign newer = cmd_r.ent.hb > cur.hb;

  // a join is stamped with the present time
  always_comb begin
    acc_cmd = q_cmd;
    if (q_cmd.op == OP_JOIN) acc_cmd.ent.tm = q_cmd.now;
  end

  // matched entry after a merge
  always_comb begin
    upd = cur;
    if (newer) begin
      upd.hb = cmd_r.ent.hb;
      upd.tm = cmd_r.now;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[k_r[IDX_W-1:0]];
  end

  always_comb begin
    st_nxt = st_r;
    mem_we = 1'b0; mem_wa = k_r[IDX_W-1:0]; mem_wd = cur;
    unique case (st_r)
      S_IDLE: if (q_valid && q_ready) begin
        st_nxt = (q_cmd.op == OP_MERGE && q_cmd.dropped) ? S_FIN : S_RD;
      end
      S_RD:   st_nxt = S_CHK;
      S_CHK: begin
        st_nxt = S_RD;
        if (cmd_r.op == OP_TICK) begin
          if (k_r == count_r) st_nxt = S_FIN;
          else if (!stale && k_r != '0) begin
            mem_we = 1'b1; mem_wa = kept_r[IDX_W-1:0];
          end
        end else if (cmd_r.op == OP_MERGE) begin
          if (k_r == count_r) st_nxt = S_FIN;
          else if (match) begin
            st_nxt = S_OUT;
            if (newer && k_r != '0) begin
              mem_we = 1'b1;
              mem_wd = upd;
            end
          end
        end else st_nxt = S_FIN;
      end
      S_FIN: begin
        st_nxt = S_OUT;
        // count never drops to zero: entry zero survives every tick
        if ((cmd_r.op == OP_JOIN || (cmd_r.op == OP_MERGE && !cmd_r.dropped))
            && count_r != TABLE_DEPTH[CNT_W-1:0]) begin
          mem_we = 1'b1; mem_wa = count_r[IDX_W-1:0];
          mem_wd = cmd_r.ent;
        end
      end
      S_OUT:  st_nxt = S_IDLE;
      S_WAIT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; count_r <= CNT_W'(1); own_hb_r <= '0; rv_r <= 1'b0;
      e0_r <= '{id: 32'd1, port: 16'd0, hb: 32'd0, tm: 31'd0};
      k_r <= '0; kept_r <= '0; rem_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT) rv_r <= 1'b1;
      else if (rv_r && res_ready) rv_r <= 1'b0;
      if (cfg_we && cfg_idx == CFG_SELF_ID)   e0_r.id   <= cfg_data;
      if (cfg_we && cfg_idx == CFG_SELF_PORT) e0_r.port <= cfg_data[15:0];
      unique case (st_r)
        S_IDLE: if (q_valid && q_ready) begin
          cmd_r <= acc_cmd;
          k_r <= (q_cmd.op == OP_READ) ? CNT_W'(q_cmd.ridx) : '0;
          kept_r <= '0; rem_r <= '0;
          if (q_cmd.op == OP_TICK) begin
            own_hb_r <= own_hb_r + 32'd1;
            e0_r.hb <= own_hb_r + 32'd1;
            e0_r.tm <= q_cmd.now;
          end
        end
        S_CHK: begin
          if (cmd_r.op == OP_TICK && k_r != count_r) begin
            if (stale) rem_r <= rem_r + 1'b1;
            else kept_r <= kept_r + 1'b1;
            k_r <= k_r + 1'b1;
          end else if (cmd_r.op == OP_MERGE && k_r != count_r) begin
            if (match) begin
              res_r.ent <= upd;
              res_r.status <= newer ? ST_UPDATED : ST_KEPT;
              if (newer && k_r == '0) begin
                e0_r.hb <= upd.hb; e0_r.tm <= upd.tm;
              end
              res_r.count <= count_r; res_r.removed <= '0;
            end else k_r <= k_r + 1'b1;
          end
        end
        S_FIN: begin
          unique case (cmd_r.op) inside
            OP_JOIN, OP_MERGE: begin
              res_r.removed <= '0;
              res_r.ent <= cmd_r.ent;
              if (cmd_r.op == OP_MERGE && cmd_r.dropped) begin
                res_r.status <= ST_DROPPED; res_r.count <= count_r;
              end else if (count_r == TABLE_DEPTH[CNT_W-1:0]) begin
                res_r.status <= ST_FULL; res_r.count <= count_r;
              end else begin
                res_r.status <= ST_ADDED;
                res_r.count <= count_r + 1'b1;
                count_r <= count_r + 1'b1;
              end
            end
            OP_TICK: begin
              res_r.status <= ST_TICKED;
              res_r.ent <= e0_r;
              res_r.count <= kept_r;
              res_r.removed <= rem_r;
              count_r <= kept_r;
            end
            OP_READ: begin
              res_r.removed <= '0;
              res_r.count <= count_r;
              if (k_r < count_r) begin
                res_r.status <= ST_READ_OK; res_r.ent <= cur;
              end else begin
                res_r.status <= ST_EMPTY; res_r.ent <= '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= TABLE_DEPTH[CNT_W-1:0])
    else $error("count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n) $rose(rv_r) |-> $past(st_r) == S_OUT)
    else $error("result outside output step");
  assert property (@(posedge clk) disable iff (!rst_n) q_ready |-> !rv_r)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (!rst_n) kept_r + rem_r == k_r || cmd_r.op != OP_TICK)
    else $error("tick bookkeeping");
endmodule

// ===== rtl/gossip_membership_table_top.sv =====
// Top level of the gossip membership table.
// Heartbeat membership table for a gossip failure detector, up to 64 entries,
// entry 0 describing this node. One beat in gives one beat out. A join or read
// passes through a read and a check step before it finishes, and a dropped merge
// goes straight to the finish step; a merge walks the table one entry at a time,
// through the single read port of the table memory, until it finds the member,
// and a tick always walks the whole table. The next command is taken in the
// cycle after the result beat leaves. A two-deep command queue sits ahead of the
// table sequencer, so up to two beats are taken while one is worked on.
// Configuration is to be written by the user only while the block is idle; the
// block itself does not enforce this.
module gossip_membership_table_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], node_id[33:2], node_port[49:34], node_heartbeat[81:50],
  // entry_time[112:82], current_time[143:113], read_index[149:144]
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], out_id[34:3], out_port[50:35], out_heartbeat[82:51],
  // out_time[113:83], table_count[120:114], removed_count[127:121]
  output logic [127:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import gmt_pkg::*;

  logic [15:0] fail_to_r, remove_to_r;
  cmd_t  in_cmd, q_cmd;
  logic  q_valid, q_ready;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_to_r <= 16'd5; remove_to_r <= 16'd20;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FAIL_TO)   fail_to_r   <= cfg_data[15:0];
      if (cfg_index == CFG_REMOVE_TO) remove_to_r <= cfg_data[15:0];
    end
  end

  always_comb begin
    in_cmd.op       = op_t'(in_tdata[1:0]);
    in_cmd.dropped  = 1'b0;
    in_cmd.ent.id   = in_tdata[33:2];
    in_cmd.ent.port = in_tdata[49:34];
    in_cmd.ent.hb   = in_tdata[81:50];
    in_cmd.ent.tm   = in_tdata[112:82];
    in_cmd.now      = in_tdata[143:113];
    in_cmd.ridx     = in_tdata[149:144];
  end

  gmt_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .fail_timeout(fail_to_r), .q_valid, .q_ready, .q_cmd
  );

  gmt_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .cfg_we, .cfg_idx(cfg_index),
    .cfg_data, .remove_timeout(remove_to_r), .res_valid(out_tvalid),
    .res_ready(out_tready), .res
  );

  assign out_tdata = {res.removed, res.count, res.ent.tm, res.ent.hb,
                      res.ent.port, res.ent.id, res.status};
endmodule

// ===== tb/gossip_membership_table_top_tb.sv =====
// Self-checking testbench for the gossip membership table: directed table plus random beats.
`timescale 1ns / 1ps
module gossip_membership_table_top_tb;
  import gmt_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // opcode, node_id, node_port, node_heartbeat, entry_time, current_time, read_index
  logic [151:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // status, out_id, out_port, out_heartbeat, out_time, table_count, removed_count
  logic [127:0] out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  gossip_membership_table_top dut (.*);

  // One input beat.
  typedef struct {
    op_t         op;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [30:0] etime;
    logic [30:0] now;
    logic [5:0]  ridx;
  } beat_t;

  // One result beat.
  typedef struct {
    status_t     st;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [30:0] tm;
    logic [6:0]  cnt;
    logic [6:0]  rem;
  } verdict_t;

  // Directed row: beat plus an optional typed-in result.
  typedef struct {
    beat_t    b;
    bit       fixed;
    verdict_t v;
  } row_t;

  // Shadow table kept by the predictor.
  logic [31:0] sh_id   [TABLE_DEPTH];
  logic [15:0] sh_port [TABLE_DEPTH];
  logic [31:0] sh_hb   [TABLE_DEPTH];
  logic [30:0] sh_tm   [TABLE_DEPTH];
  int          sh_cnt;
  logic [31:0] sh_own_hb;
  logic [15:0] fail_to, remove_to;
  logic [31:0] self_id;
  logic [15:0] self_port;

  verdict_t pending_q[$];
  int       errors;
  int       send_idle_pct, recv_idle_pct;
  bit       hold_off;

  // Clock: 4 ns period.
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic verdict_t mk(status_t st, int k, int rem);
    verdict_t v;
    v.st = st; v.id = sh_id[k]; v.port = sh_port[k]; v.hb = sh_hb[k];
    v.tm = sh_tm[k]; v.cnt = 7'(sh_cnt); v.rem = 7'(rem);
    return v;
  endfunction

  function automatic verdict_t echo(status_t st, beat_t b, logic [30:0] t);
    verdict_t v;
    v.st = st; v.id = b.id; v.port = b.port; v.hb = b.hb;
    v.tm = t; v.cnt = 7'(sh_cnt); v.rem = '0;
    return v;
  endfunction

  // Signed age: now - then, negative when then is in the future.
  function automatic longint age(logic [30:0] now, logic [30:0] then_t);
    return longint'(now) - longint'(then_t);
  endfunction

  // Applies one beat to the shadow table and returns the predicted result.
  function automatic verdict_t predict_membership(beat_t b);
    int kept, removed;
    case (b.op) inside
      OP_JOIN, OP_MERGE: begin
        logic [30:0] t;
        t = (b.op == OP_JOIN) ? b.now : b.etime;
        if (b.op == OP_MERGE) begin
          if (age(b.now, b.etime) >= longint'(fail_to)) return echo(ST_DROPPED, b, b.etime);
          for (int k = 0; k < sh_cnt; k++) begin
            if (sh_id[k] == b.id && sh_port[k] == b.port) begin
              if (b.hb > sh_hb[k]) begin
                sh_hb[k] = b.hb; sh_tm[k] = b.now;
                return mk(ST_UPDATED, k, 0);
              end
              return mk(ST_KEPT, k, 0);
            end
          end
        end
        if (sh_cnt >= TABLE_DEPTH) return echo(ST_FULL, b, t);
        sh_id[sh_cnt] = b.id; sh_port[sh_cnt] = b.port;
        sh_hb[sh_cnt] = b.hb; sh_tm[sh_cnt] = t;
        sh_cnt++;
        return mk(ST_ADDED, sh_cnt - 1, 0);
      end
      OP_TICK: begin
        kept = 0; removed = 0;
        sh_own_hb++;
        sh_hb[0] = sh_own_hb; sh_tm[0] = b.now;
        for (int k = 0; k < sh_cnt; k++) begin
          if (age(b.now, sh_tm[k]) > longint'(remove_to)) removed++;
          else begin
            sh_id[kept] = sh_id[k]; sh_port[kept] = sh_port[k];
            sh_hb[kept] = sh_hb[k]; sh_tm[kept] = sh_tm[k];
            kept++;
          end
        end
        sh_cnt = kept;
        return mk(ST_TICKED, 0, removed);
      end
      default: begin
        verdict_t v;
        if (b.ridx < sh_cnt) return mk(ST_READ_OK, b.ridx, 0);
        v = '{ST_EMPTY, '0, '0, '0, '0, 7'(sh_cnt), '0};
        return v;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FAIL_TO:   fail_to = val[15:0];
      CFG_REMOVE_TO: remove_to = val[15:0];
      CFG_SELF_ID:   begin self_id = val; sh_id[0] = val; end
      CFG_SELF_PORT: begin self_port = val[15:0]; sh_port[0] = val[15:0]; end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Sends one beat; the predictor runs at acceptance. Valid stays up after
  // acceptance until the next beat or an idle cycle replaces it.
  task automatic send_beat(beat_t b, bit fixed, verdict_t v);
    verdict_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b0, b.ridx, b.now, b.etime, b.hb, b.port, b.id, 2'(b.op)};
    do @(posedge clk); while (!in_tready);
    p = predict_membership(b);
    pending_q.insert(pending_q.size(), fixed ? v : p);
  endtask

  // Waits until every expected result has come back, plus slack for the pipeline.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic beat_t rand_beat();
    beat_t b;
    int pick;
    b.op    = op_t'($urandom_range(3));
    b.now   = 31'($urandom_range(200, 20));
    b.etime = 31'($urandom_range(220, 0));
    b.hb    = $urandom_range(40);
    b.ridx  = 6'($urandom);
    // Mostly reuse known members so merges hit the update and keep paths.
    pick = $urandom_range(sh_cnt - 1);
    if ($urandom_range(3) != 0) begin
      b.id = sh_id[pick]; b.port = sh_port[pick];
    end else begin
      b.id = $urandom; b.port = 16'($urandom);
    end
    if ($urandom_range(15) == 0) begin
      b.hb = $urandom; b.now = 31'($urandom); b.etime = 31'($urandom);
    end
    return b;
  endfunction

  // Result checker: compares each beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      verdict_t w;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], '0);
      end else begin
        w = pending_q.pop_front();
        if (out_tdata[2:0] != w.st) report_mismatch("status", out_tdata[2:0], w.st);
        if (out_tdata[34:3] != w.id) report_mismatch("id", out_tdata[34:3], w.id);
        if (out_tdata[50:35] != w.port) report_mismatch("port", out_tdata[50:35], w.port);
        if (out_tdata[82:51] != w.hb) report_mismatch("heartbeat", out_tdata[82:51], w.hb);
        if (out_tdata[113:83] != w.tm) report_mismatch("time", out_tdata[113:83], w.tm);
        if (out_tdata[120:114] != w.cnt) report_mismatch("count", out_tdata[120:114], w.cnt);
        if (out_tdata[127:121] != w.rem)
          report_mismatch("removed", out_tdata[127:121], w.rem);
      end
    end
  end

  // Receiver: random backpressure, plus a long hold-off window.
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    row_t  rows[$];
    beat_t b;
    verdict_t nv;
    errors = 0; hold_off = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    rst_n = 0;
    fail_to = 16'd5; remove_to = 16'd20; self_id = 32'd1; self_port = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      sh_id[k] = '0; sh_port[k] = '0; sh_hb[k] = '0; sh_tm[k] = '0;
    end
    sh_id[0] = 32'd1; sh_cnt = 1; sh_own_hb = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    nv = '{ST_ADDED, '0, '0, '0, '0, '0, '0};

    // Directed table. Typed results: reset state, empty read, dropped echo.
    rows.insert(rows.size(), '{'{OP_READ, 0, 0, 0, 0, 0, 6'd0}, 1,
                     '{ST_READ_OK, 32'd1, 16'd0, 32'd0, 31'd0, 7'd1, 7'd0}});
    rows.insert(rows.size(), '{'{OP_READ, 0, 0, 0, 0, 0, 6'd63}, 1,
                     '{ST_EMPTY, 32'd0, 16'd0, 32'd0, 31'd0, 7'd1, 7'd0}});
    rows.insert(rows.size(), '{'{OP_MERGE, 32'h8000_0000, 16'h8000, 32'hFFFF_FFFF, 31'd0,
                     31'd5, 6'd0}, 1,
                     '{ST_DROPPED, 32'h8000_0000, 16'h8000, 32'hFFFF_FFFF, 31'd0, 7'd1, 7'd0}});
    rows.insert(rows.size(), '{'{OP_JOIN, 32'h7FFF_FFFF, 16'h7FFF, 32'hFFFF_FFFF, 0,
                     31'h7FFF_FFFF, 6'd0}, 0, nv});
    rows.insert(rows.size(), '{'{OP_JOIN, 32'h8000_0000, 16'h8000, 32'd0, 0, 31'd0, 6'd0},
                     0, nv});
    rows.insert(rows.size(), '{'{OP_MERGE, 32'd5, 16'd9, 32'd3, 31'd10, 31'd12, 6'd0}, 0, nv});
    rows.insert(rows.size(), '{'{OP_MERGE, 32'd5, 16'd9, 32'd7, 31'd10, 31'd13, 6'd0}, 0, nv});
    rows.insert(rows.size(), '{'{OP_MERGE, 32'd5, 16'd9, 32'd7, 31'd10, 31'd13, 6'd0}, 0, nv});
    rows.insert(rows.size(), '{'{OP_MERGE, 32'd5, 16'd9, 32'd1, 31'd13, 31'd12, 6'd0}, 0, nv});
    // Own entry matches like any other.
    rows.insert(rows.size(), '{'{OP_MERGE, 32'd1, 16'd0, 32'd4, 31'd12, 31'd12, 6'd0}, 0, nv});
    rows.insert(rows.size(), '{'{OP_READ, 0, 0, 0, 0, 0, 6'd3}, 0, nv});
    // Tick far ahead erases stale entries, entry zero survives.
    rows.insert(rows.size(), '{'{OP_TICK, 0, 0, 0, 0, 31'd40, 6'd0}, 0, nv});
    rows.insert(rows.size(), '{'{OP_TICK, 0, 0, 0, 0, 31'h7FFF_FFFF, 6'd0}, 0, nv});
    rows.insert(rows.size(), '{'{OP_READ, 0, 0, 0, 0, 0, 6'd1}, 0, nv});
    foreach (rows[i]) send_beat(rows[i].b, rows[i].fixed, rows[i].v);
    drain();

    // Fill the table to its limit, hit full on join and merge.
    for (int k = 0; k < TABLE_DEPTH + 1; k++)
      send_beat('{OP_JOIN, 32'(k + 100), 16'(k), 32'(k), 0, 31'd50, 6'(k)}, 0, nv);
    send_beat('{OP_MERGE, 32'd9999, 16'd1, 32'd1, 31'd50, 31'd50, 0}, 0, nv);
    send_beat('{OP_READ, 0, 0, 0, 0, 0, 6'd63}, 0, nv);
    send_beat('{OP_TICK, 0, 0, 0, 0, 31'd100, 0}, 0, nv);
    drain();

    // Random phases under several register settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_FAIL_TO, 32'd65535); write_reg(CFG_REMOVE_TO, 32'd1);
                 write_reg(CFG_SELF_ID, 32'h8000_0000); write_reg(CFG_SELF_PORT, 32'h8000); end
        1: begin write_reg(CFG_FAIL_TO, 32'd1); write_reg(CFG_REMOVE_TO, 32'd65535);
                 write_reg(CFG_SELF_ID, 32'h7FFF_FFFF); write_reg(CFG_SELF_PORT, 32'h7FFF); end
        2: begin write_reg(CFG_FAIL_TO, 32'd0); write_reg(CFG_REMOVE_TO, 32'd0); end
        default: begin write_reg(CFG_FAIL_TO, 32'($urandom_range(120, 5)));
                       write_reg(CFG_REMOVE_TO, 32'($urandom_range(150, 30)));
                       write_reg(CFG_SELF_ID, $urandom); write_reg(CFG_SELF_PORT, $urandom); end
      endcase
      case (ph)
        0, 1: begin send_idle_pct = 11; recv_idle_pct = 84; end
        2, 3: begin send_idle_pct = 84; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 4) begin
        // Long stall on the result side while beats keep coming.
        fork
          begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
        join_none
      end
      for (int n = 0; n < 140; n++) begin
        b = rand_beat();
        send_beat(b, 0, nv);
      end
      drain();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
